// ===== hdl/hkts_pkg.sv =====
// ============================================================================
// hkts_pkg - shared types and constants for the hashed key toggle set
// Operation codes, state encoding, result record and the FNV-1a byte step.
// ============================================================================
package hkts_pkg;

    // FNV-1a 32-bit constants
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Stream widths in bits (zero padded) and the result count width
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;
    localparam int COUNT_W   = 7;

    // Operation codes carried in the input tuser
    typedef enum logic [2:0] {
        OP_TOGGLE    = 3'd0,
        OP_QUERY     = 3'd1,
        OP_LOAD_HASH = 3'd2,
        OP_CLEAR     = 3'd3,
        OP_LOAD_KEY  = 3'd4
    } t_op;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_WAIT
    } t_state;

    // One result item
    typedef struct packed {
        logic [31:0]        hash;
        logic [COUNT_W-1:0] count;
        logic               rejected;
        logic               removed;
        logic               member;
    } t_result;

    // One FNV-1a step: xor the byte in, multiply by the prime modulo 2^32
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return 32'(x * FNV_PRIME);
    endfunction

endpackage

// ===== hdl/hkts_ram.sv =====
// ============================================================================
// hkts_ram - key table storage
// Single write port, single read port, read data registered.
// ============================================================================
module hkts_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [31:0]       i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [31:0]       o_rd_data
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    // Write and registered read; contents undefined until written
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/hashed_key_toggle_set_core.sv =====
// ============================================================================
// hashed_key_toggle_set_core - ordered membership table of FNV-1a key hashes
// Key bytes are hashed one per transfer; the last transfer of a key toggles,
// queries or loads it in a table held in one synchronous RAM.
// ============================================================================
//
//  Channel  | Direction | tdata (low bit up)                  | tuser / tlast
//  ---------+-----------+-------------------------------------+---------------------------
//  s_axis   | in        | key_byte[7:0], stored_hash[39:8]    | operation[2:0], has_byte[3];
//           |           |                                     | tlast = last_byte
//  m_axis   | out       | entry_count[6:0], key_hash[38:7]    | is_member[0], removed[1],
//           |           |                                     | rejected[2]
//
//  A key byte, a load hash word or a clear is handled in the idle state. The
//  last transfer of a toggle or query walks the RAM one entry a cycle from
//  entry 0 until a match or the end; a toggle that removes an entry then
//  reads and writes back each later entry, one place down. The single RAM
//  read port sets this pace. Reset: synchronous, active low; clears the
//  count and the output valid and sets the hash to the FNV basis; the RAM
//  is not cleared. A result waiting in the output register does not stop
//  input transfers; only a second result blocks until the first is taken.
module hashed_key_toggle_set_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // in: key_byte[7:0], stored_hash[39:8]
    input  logic [hkts_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // in: operation[2:0], has_byte[3]
    input  logic [hkts_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  logic                           s_axis_tlast,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // out: entry_count[6:0], key_hash[38:7], zero[39]
    output logic [hkts_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // out: is_member[0], removed[1], rejected[2]
    output logic [hkts_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = CW + 1;

    // Registers
    hkts_pkg::t_state  r_state, n_state;
    logic [31:0]       r_hash, n_hash;
    logic              r_started, n_started;
    logic [CW-1:0]     r_count, n_count;
    logic [31:0]       r_key, n_key;
    logic              r_toggle, n_toggle;
    logic [AW-1:0]     r_ptr, n_ptr;
    hkts_pkg::t_result r_pend;
    hkts_pkg::t_result r_out;
    logic              r_out_valid;

    // Combinational
    hkts_pkg::t_result res;
    logic              res_fire;
    logic              slot_free;
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [31:0]       wr_data;
    logic [31:0]       rd_data;
    logic [31:0]       step_hash, key_hash;
    logic              key_started;
    logic              room;
    logic              hit;
    logic [AW-1:0]     ptr_inc1, ptr_inc2;
    logic [IW-1:0]     pos_inc1, pos_inc2;
    hkts_pkg::t_op     in_op;

    // Table RAM
    hkts_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign in_op     = hkts_pkg::t_op'(s_axis_tuser[2:0]);
    assign slot_free = !r_out_valid || m_axis_tready;
    assign ptr_inc1  = r_ptr + AW'(1);
    assign ptr_inc2  = ptr_inc1 + AW'(1);
    assign pos_inc1  = IW'(r_ptr) + IW'(1);
    assign pos_inc2  = pos_inc1 + IW'(1);
    assign room      = (r_count < CW'(TABLE_DEPTH));

    // Next state, RAM control and result
    always_comb begin
        n_state       = r_state;
        n_hash        = r_hash;
        n_started     = r_started;
        n_count       = r_count;
        n_key         = r_key;
        n_toggle      = r_toggle;
        n_ptr         = r_ptr;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = r_key;
        res_fire      = 1'b0;
        res           = '0;
        s_axis_tready = 1'b0;
        step_hash     = hkts_pkg::fnv_step(r_hash, s_axis_tdata[7:0]);
        key_hash      = s_axis_tuser[3] ? step_hash : r_hash;
        key_started   = r_started | s_axis_tuser[3];
        hit           = (r_count != '0) && (rd_data == r_key);

        case (r_state)
            hkts_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    case (in_op)
                        hkts_pkg::OP_LOAD_HASH: begin
                            n_hash    = hkts_pkg::FNV_BASIS;
                            n_started = 1'b0;
                            res_fire  = 1'b1;
                            res.hash  = s_axis_tdata[39:8];
                            if (room) begin
                                wr_en      = 1'b1;
                                wr_addr    = r_count[AW-1:0];
                                wr_data    = s_axis_tdata[39:8];
                                n_count    = r_count + CW'(1);
                                res.member = 1'b1;
                            end else begin
                                res.rejected = 1'b1;
                            end
                        end
                        hkts_pkg::OP_CLEAR: begin
                            n_hash    = hkts_pkg::FNV_BASIS;
                            n_started = 1'b0;
                            n_count   = '0;
                            res_fire  = 1'b1;
                        end
                        hkts_pkg::OP_TOGGLE, hkts_pkg::OP_QUERY, hkts_pkg::OP_LOAD_KEY: begin
                            if (!s_axis_tlast) begin
                                n_hash    = key_hash;
                                n_started = key_started;
                            end else begin
                                n_hash    = hkts_pkg::FNV_BASIS;
                                n_started = 1'b0;
                                n_key     = key_hash;
                                res.hash  = key_hash;
                                if (!key_started) begin
                                    // empty key
                                    res_fire     = 1'b1;
                                    res.rejected = 1'b1;
                                end else if (in_op == hkts_pkg::OP_LOAD_KEY) begin
                                    res_fire = 1'b1;
                                    if (room) begin
                                        wr_en      = 1'b1;
                                        wr_addr    = r_count[AW-1:0];
                                        wr_data    = key_hash;
                                        n_count    = r_count + CW'(1);
                                        res.member = 1'b1;
                                    end else begin
                                        res.rejected = 1'b1;
                                    end
                                end else begin
                                    // start the scan at entry 0
                                    n_toggle = (in_op == hkts_pkg::OP_TOGGLE);
                                    n_ptr    = '0;
                                    rd_en    = 1'b1;
                                    rd_addr  = '0;
                                    n_state  = hkts_pkg::S_SEARCH;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            hkts_pkg::S_SEARCH: begin
                res.hash = r_key;
                if (hit) begin
                    if (!r_toggle) begin
                        res_fire   = 1'b1;
                        res.member = 1'b1;
                    end else if (pos_inc1 < IW'(r_count)) begin
                        // close the gap from the match onwards
                        rd_en   = 1'b1;
                        rd_addr = ptr_inc1;
                        n_state = hkts_pkg::S_SHIFT;
                    end else begin
                        n_count     = r_count - CW'(1);
                        res_fire    = 1'b1;
                        res.removed = 1'b1;
                    end
                end else if (pos_inc1 < IW'(r_count)) begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_inc1;
                    n_ptr   = ptr_inc1;
                end else begin
                    // key absent
                    res_fire = 1'b1;
                    if (r_toggle) begin
                        if (room) begin
                            wr_en      = 1'b1;
                            wr_addr    = r_count[AW-1:0];
                            wr_data    = r_key;
                            n_count    = r_count + CW'(1);
                            res.member = 1'b1;
                        end else begin
                            res.rejected = 1'b1;
                        end
                    end
                end
            end

            hkts_pkg::S_SHIFT: begin
                // entry ptr+1 is in the read register: move it down one place
                res.hash = r_key;
                wr_en    = 1'b1;
                wr_addr  = r_ptr;
                wr_data  = rd_data;
                if (pos_inc2 < IW'(r_count)) begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_inc2;
                    n_ptr   = ptr_inc1;
                end else begin
                    n_count     = r_count - CW'(1);
                    res_fire    = 1'b1;
                    res.removed = 1'b1;
                end
            end

            hkts_pkg::S_WAIT: begin
                if (slot_free) begin
                    n_state = hkts_pkg::S_IDLE;
                end
            end

            default: n_state = hkts_pkg::S_IDLE;
        endcase

        res.count = hkts_pkg::COUNT_W'(n_count);
        if (res_fire) begin
            n_state = slot_free ? hkts_pkg::S_IDLE : hkts_pkg::S_WAIT;
        end
    end

    // Control and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hkts_pkg::S_IDLE;
            r_hash    <= hkts_pkg::FNV_BASIS;
            r_started <= 1'b0;
            r_count   <= '0;
            r_toggle  <= 1'b0;
            r_ptr     <= '0;
        end else begin
            r_state   <= n_state;
            r_hash    <= n_hash;
            r_started <= n_started;
            r_count   <= n_count;
            r_toggle  <= n_toggle;
            r_ptr     <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (res_fire) begin
            r_pend <= res;
        end
    end

    // Output register: loaded straight from a new result or from the held one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_fire && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (r_state == hkts_pkg::S_WAIT && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_fire && slot_free) begin
            r_out <= res;
        end else if (r_state == hkts_pkg::S_WAIT && slot_free) begin
            r_out <= r_pend;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.hash, r_out.count};
    assign m_axis_tuser  = {r_out.rejected, r_out.removed, r_out.member};

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && in_op == hkts_pkg::OP_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the table");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hkts_pkg::S_SHIFT) |-> (pos_inc1 < IW'(r_count)))
        else $error("shift pointer past the last entry");

    a_wait_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hkts_pkg::S_WAIT) |-> r_out_valid)
        else $error("held result with an empty output register");

endmodule

// ===== tb/sv/tb_hashed_key_toggle_set_core.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_hashed_key_toggle_set_core - self-checking bench for the key toggle set
// Streams key bytes, hash words, clears and spare codes into the core with
// random gaps and back-pressure, predicts results with an independent
// FNV-1a table model or fixed rows and checks each result field by field.
// ============================================================================
module tb_hashed_key_toggle_set_core;

    localparam int          CLK_PERIOD    = 10;
    localparam int          TABLE_DEPTH   = 64;
    localparam int          RANDOM_ITEMS  = 1080;
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          SETTLE_CYCLES = 200;
    localparam int          POOL_KEYS     = 96;
    localparam logic [31:0] HASH_SEED     = 32'h811C9DC5;
    localparam logic [31:0] HASH_MULT     = 32'h01000193;
    localparam logic [2:0]  OP_SPARE_LO   = 3'd5;

    // One input transfer; want is used only for rows with a typed result
    typedef struct {
        logic [2:0]        op;
        logic [7:0]        kbyte;
        bit                has;
        bit                last;
        logic [31:0]       word;
        bit                typed;
        hkts_pkg::t_result want;
    } t_beat;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    // key_byte[7:0], stored_hash[39:8]
    logic [hkts_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    // operation[2:0], has_byte[3]
    logic [hkts_pkg::S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                           s_axis_tlast  = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // entry_count[6:0], key_hash[38:7]
    logic [hkts_pkg::M_TDATA_W-1:0] m_axis_tdata;
    // is_member[0], removed[1], rejected[2]
    logic [hkts_pkg::M_TUSER_W-1:0] m_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;

    // Predicted core state
    logic [31:0] p_hash     = HASH_SEED;
    bit          p_key_open = 1'b0;
    logic [31:0] p_keys [TABLE_DEPTH];
    int          p_count    = 0;

    hkts_pkg::t_result pending_results [$];
    t_beat             dir_rows [$];
    logic [7:0]        pool_bytes [POOL_KEYS][8];
    int                pool_len [POOL_KEYS];

    bit          idle_en      = 1'b1;
    int          beats_sent   = 0;
    int          errors       = 0;
    int          quiet_cycles = 0;
    int          cycle_no     = 0;
    int          stall_left   = 0;
    int          n_results    = 0;
    int          n_removed    = 0;
    int          n_rejected   = 0;
    int          peak_count   = 0;

    hashed_key_toggle_set_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    function automatic int find_entry(input logic [31:0] h);
        for (int i = 0; i < p_count; i++)
            if (p_keys[i] == h) return i;
        return -1;
    endfunction

    function automatic bit append_entry(input logic [31:0] h);
        if (p_count >= TABLE_DEPTH) return 1'b0;
        p_keys[p_count] = h;
        p_count++;
        return 1'b1;
    endfunction

    // Table behaviour for one accepted input transfer
    task automatic predict_set_action(input t_beat b, output bit got,
                                      output hkts_pkg::t_result res);
        int pos;
        got = 1'b0;
        res = '0;
        case (b.op)
            hkts_pkg::OP_LOAD_HASH: begin
                p_hash     = HASH_SEED;
                p_key_open = 1'b0;
                res.hash   = b.word;
                if (append_entry(b.word)) res.member = 1'b1;
                else                      res.rejected = 1'b1;
                got = 1'b1;
            end
            hkts_pkg::OP_CLEAR: begin
                p_hash     = HASH_SEED;
                p_key_open = 1'b0;
                p_count    = 0;
                got        = 1'b1;
            end
            hkts_pkg::OP_TOGGLE, hkts_pkg::OP_QUERY, hkts_pkg::OP_LOAD_KEY: begin
                if (b.has) begin
                    p_hash     = (p_hash ^ {24'd0, b.kbyte}) * HASH_MULT;
                    p_key_open = 1'b1;
                end
                if (b.last) begin
                    got      = 1'b1;
                    res.hash = p_hash;
                    if (!p_key_open) begin
                        res.rejected = 1'b1;
                    end else if (b.op == hkts_pkg::OP_QUERY) begin
                        res.member = (find_entry(p_hash) >= 0);
                    end else if (b.op == hkts_pkg::OP_LOAD_KEY) begin
                        if (append_entry(p_hash)) res.member = 1'b1;
                        else                      res.rejected = 1'b1;
                    end else begin
                        pos = find_entry(p_hash);
                        if (pos >= 0) begin
                            // close the gap, keeping order
                            for (int m = pos; m + 1 < p_count; m++) p_keys[m] = p_keys[m + 1];
                            p_count--;
                            res.removed = 1'b1;
                        end else if (append_entry(p_hash)) begin
                            res.member = 1'b1;
                        end else begin
                            res.rejected = 1'b1;
                        end
                    end
                    p_hash     = HASH_SEED;
                    p_key_open = 1'b0;
                end
            end
            default: ;  // spare codes are ignored
        endcase
        res.count = 7'(p_count);
    endtask

    function automatic t_beat make_beat(input logic [2:0] op, input logic [7:0] kb,
                                        input bit has, input bit last, input logic [31:0] w);
        t_beat b;
        b.op    = op;
        b.kbyte = kb;
        b.has   = has;
        b.last  = last;
        b.word  = w;
        b.typed = 1'b0;
        b.want  = '0;
        return b;
    endfunction

    function automatic t_beat fixed_row(input t_beat b, input bit mem, input bit rem,
                                        input bit rej, input int cnt, input logic [31:0] h);
        b.typed         = 1'b1;
        b.want.member   = mem;
        b.want.removed  = rem;
        b.want.rejected = rej;
        b.want.count    = 7'(cnt);
        b.want.hash     = h;
        return b;
    endfunction

    function automatic logic [31:0] pool_key_hash(input int k);
        logic [31:0] h;
        h = HASH_SEED;
        for (int i = 0; i < pool_len[k]; i++) h = (h ^ {24'd0, pool_bytes[k][i]}) * HASH_MULT;
        return h;
    endfunction

    function automatic logic [2:0] any_key_op();
        case ($urandom_range(0, 2))
            0:       return hkts_pkg::OP_TOGGLE;
            1:       return hkts_pkg::OP_QUERY;
            default: return hkts_pkg::OP_LOAD_KEY;
        endcase
    endfunction

    // Present one transfer, wait for acceptance, then record what it must cause
    task automatic send_beat(input t_beat b);
        int                gap;
        bit                got;
        hkts_pkg::t_result res;
        if (idle_en && ((beats_sent / 100) % 4 != 3) && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {b.word, b.kbyte};
        s_axis_tuser  <= {b.has, b.op};
        s_axis_tlast  <= b.last;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_set_action(b, got, res);
        if (got) pending_results.push_back(b.typed ? b.want : res);
        if (b.op <= hkts_pkg::OP_LOAD_KEY) beats_sent++;
    endtask

    // Key from the pool with occasional byte-less transfers, foreign codes
    // on inner bytes and a byte-less closing transfer
    task automatic send_key(input int k, input logic [2:0] final_op);
        bit  bare_end;
        bit  last;
        bare_end = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < pool_len[k]; i++) begin
            if ($urandom_range(0, 11) == 0)
                send_beat(make_beat(any_key_op(), 8'($urandom), 1'b0, 1'b0, $urandom));
            last = !bare_end && (i == pool_len[k] - 1);
            send_beat(make_beat((last || $urandom_range(0, 9) != 0) ? final_op : any_key_op(),
                                pool_bytes[k][i], 1'b1, last, $urandom));
        end
        if (bare_end) send_beat(make_beat(final_op, 8'($urandom), 1'b0, 1'b1, $urandom));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Result receiver: stall bursts with idle-free windows
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_en && ((cycle_no / 700) % 4 != 1) && $urandom_range(0, 6) == 0) begin
            stall_left    <= $urandom_range(0, 17);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result checker and activity counter
    always @(posedge i_clk) begin
        hkts_pkg::t_result got;
        hkts_pkg::t_result exp;
        cycle_no <= cycle_no + 1;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.member   = m_axis_tuser[0];
            got.removed  = m_axis_tuser[1];
            got.rejected = m_axis_tuser[2];
            got.count    = m_axis_tdata[6:0];
            got.hash     = m_axis_tdata[38:7];
            n_results++;
            if (got.removed)  n_removed++;
            if (got.rejected) n_rejected++;
            if (int'(got.count) > peak_count) peak_count = int'(got.count);
            if (pending_results.size() == 0) begin
                flag_error($sformatf({"result with nothing expected: member %0b removed %0b ",
                                      "rejected %0b count %0d hash %08h"},
                                     got.member, got.removed, got.rejected, got.count,
                                     got.hash));
            end else begin
                exp = pending_results.pop_front();
                if (got.member !== exp.member || got.removed !== exp.removed ||
                    got.rejected !== exp.rejected || got.count !== exp.count ||
                    got.hash !== exp.hash)
                    flag_error($sformatf({"result %0d mismatch: expected member %0b removed %0b ",
                                          "rejected %0b count %0d hash %08h, got %0b %0b %0b %0d %08h"},
                                         n_results, exp.member, exp.removed, exp.rejected,
                                         exp.count, exp.hash, got.member, got.removed,
                                         got.rejected, got.count, got.hash));
            end
        end
    end

    // Watchdog: no transfer on either side for too long
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus
    initial begin
        int  rand_start;
        int  pick;
        int  k;
        int  n;
        bit  fill_mode;
        bit  paused;
        logic [2:0] fop;
        logic [31:0] w;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // key pool: mostly short keys, a few up to eight bytes
        for (int i = 0; i < POOL_KEYS; i++) begin
            pool_len[i] = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
            for (int j = 0; j < 8; j++) pool_bytes[i][j] = 8'($urandom);
        end

        // directed rows
        // empty key after reset
        dir_rows.push_back(fixed_row(make_beat(hkts_pkg::OP_TOGGLE, 8'h00, 1'b0, 1'b1, 32'h0),
                                     1'b0, 1'b0, 1'b1, 0, HASH_SEED));
        dir_rows.push_back(fixed_row(make_beat(hkts_pkg::OP_QUERY, 8'hFF, 1'b0, 1'b1,
                                               32'hFFFFFFFF),
                                     1'b0, 1'b0, 1'b1, 0, HASH_SEED));
        dir_rows.push_back(fixed_row(make_beat(hkts_pkg::OP_LOAD_HASH, 8'h00, 1'b0, 1'b0,
                                               32'hFFFFFFFF),
                                     1'b1, 1'b0, 1'b0, 1, 32'hFFFFFFFF));
        dir_rows.push_back(fixed_row(make_beat(hkts_pkg::OP_LOAD_HASH, 8'hFF, 1'b1, 1'b1,
                                               32'h0),
                                     1'b1, 1'b0, 1'b0, 2, 32'h0));
        dir_rows.push_back(fixed_row(make_beat(hkts_pkg::OP_CLEAR, 8'hFF, 1'b1, 1'b1,
                                               32'hFFFFFFFF),
                                     1'b0, 1'b0, 1'b0, 0, 32'h0));
        // key in progress, then added
        dir_rows.push_back(make_beat(hkts_pkg::OP_TOGGLE, 8'h00, 1'b1, 1'b0, 32'h0));
        dir_rows.push_back(make_beat(hkts_pkg::OP_TOGGLE, 8'hFF, 1'b1, 1'b1, 32'h0));
        // present
        dir_rows.push_back(make_beat(hkts_pkg::OP_QUERY, 8'h00, 1'b1, 1'b0, 32'h0));
        dir_rows.push_back(make_beat(hkts_pkg::OP_QUERY, 8'hFF, 1'b1, 1'b1, 32'h0));
        dir_rows.push_back(make_beat(OP_SPARE_LO, 8'h5A, 1'b1, 1'b1, 32'h12345678));
        dir_rows.push_back(make_beat(OP_SPARE_LO + 3'd1, 8'hA5, 1'b0, 1'b0, 32'hFFFFFFFF));
        dir_rows.push_back(make_beat(OP_SPARE_LO + 3'd2, 8'hFF, 1'b1, 1'b1, 32'h0));
        // mixed codes, a byte-less transfer, then removed
        dir_rows.push_back(make_beat(hkts_pkg::OP_QUERY, 8'h00, 1'b1, 1'b0, 32'h0));
        dir_rows.push_back(make_beat(hkts_pkg::OP_TOGGLE, 8'h55, 1'b0, 1'b0, 32'h0));
        dir_rows.push_back(make_beat(hkts_pkg::OP_TOGGLE, 8'hFF, 1'b1, 1'b1, 32'h0));
        // byte-less end, duplicate load, first copy goes
        dir_rows.push_back(make_beat(hkts_pkg::OP_LOAD_KEY, 8'h41, 1'b1, 1'b0, 32'h0));
        dir_rows.push_back(make_beat(hkts_pkg::OP_LOAD_KEY, 8'h00, 1'b0, 1'b1, 32'h0));
        dir_rows.push_back(make_beat(hkts_pkg::OP_LOAD_KEY, 8'h41, 1'b1, 1'b1, 32'h0));
        dir_rows.push_back(make_beat(hkts_pkg::OP_TOGGLE, 8'h41, 1'b1, 1'b1, 32'h0));
        // word load drops the key in progress
        dir_rows.push_back(make_beat(hkts_pkg::OP_TOGGLE, 8'h12, 1'b1, 1'b0, 32'h0));
        dir_rows.push_back(make_beat(hkts_pkg::OP_LOAD_HASH, 8'h00, 1'b0, 1'b0, 32'hA5A5A5A5));
        dir_rows.push_back(make_beat(hkts_pkg::OP_TOGGLE, 8'h34, 1'b1, 1'b1, 32'h0));
        dir_rows.push_back(fixed_row(make_beat(hkts_pkg::OP_CLEAR, 8'h00, 1'b0, 1'b0, 32'h0),
                                     1'b0, 1'b0, 1'b0, 0, 32'h0));
        // gone after clear
        dir_rows.push_back(make_beat(hkts_pkg::OP_QUERY, 8'h34, 1'b1, 1'b1, 32'h0));
        dir_rows.push_back(fixed_row(make_beat(hkts_pkg::OP_LOAD_KEY, 8'hC3, 1'b0, 1'b1, 32'h0),
                                     1'b0, 1'b0, 1'b1, 0, HASH_SEED));
        foreach (dir_rows[i]) send_beat(dir_rows[i]);

        // hold off until the table is settled, then run it full
        drain_results();
        send_beat(make_beat(hkts_pkg::OP_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom),
                            $urandom));
        send_beat(make_beat(hkts_pkg::OP_LOAD_HASH, 8'($urandom), 1'($urandom), 1'($urandom),
                            pool_key_hash(0)));
        // the last one is rejected
        for (int i = 1; i <= TABLE_DEPTH; i++)
            send_beat(make_beat(hkts_pkg::OP_LOAD_HASH, 8'($urandom), 1'($urandom),
                                1'($urandom), $urandom));
        send_key(1, hkts_pkg::OP_LOAD_KEY);
        send_key(2, hkts_pkg::OP_TOGGLE);
        send_key(0, hkts_pkg::OP_QUERY);
        send_key(0, hkts_pkg::OP_TOGGLE);     // head entry out, whole table shifts
        send_key(0, hkts_pkg::OP_TOGGLE);     // back in at the tail
        send_key(0, hkts_pkg::OP_TOGGLE);     // tail entry out

        // random part: mostly complete keys, some loads, clears and noise
        rand_start = beats_sent;
        paused     = 1'b0;
        while (beats_sent - rand_start < RANDOM_ITEMS) begin
            fill_mode = ((beats_sent / 150) % 2 == 0);
            if (beats_sent - rand_start >= RANDOM_ITEMS - 150) idle_en = 1'b0;
            if (!paused && beats_sent - rand_start >= RANDOM_ITEMS / 2) begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                send_beat(make_beat(hkts_pkg::OP_CLEAR, 8'($urandom), 1'($urandom),
                                    1'($urandom), $urandom));
            end else if (pick < 10) begin
                case ($urandom_range(0, 2))
                    0:       w = $urandom;
                    1:       w = (p_count > 0) ? p_keys[$urandom_range(0, p_count - 1)] : $urandom;
                    default: w = pool_key_hash($urandom_range(0, POOL_KEYS - 1));
                endcase
                send_beat(make_beat(hkts_pkg::OP_LOAD_HASH, 8'($urandom), 1'($urandom),
                                    1'($urandom), w));
            end else if (pick < 13) begin
                send_beat(make_beat(OP_SPARE_LO + 3'($urandom_range(0, 2)), 8'($urandom),
                                    1'($urandom), 1'($urandom), $urandom));
            end else if (pick < 17) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_beat(make_beat(any_key_op(), 8'($urandom), 1'b0, 1'b1, $urandom));
                end else begin
                    // key cut short by a word load or a clear
                    k = $urandom_range(0, POOL_KEYS - 1);
                    n = $urandom_range(1, pool_len[k]);
                    for (int i = 0; i < n; i++)
                        send_beat(make_beat(any_key_op(), pool_bytes[k][i], 1'b1, 1'b0, $urandom));
                    fop = $urandom_range(0, 1) ? hkts_pkg::OP_CLEAR : hkts_pkg::OP_LOAD_HASH;
                    send_beat(make_beat(fop, 8'($urandom), 1'($urandom), 1'($urandom),
                                        $urandom));
                end
            end else begin
                pick = $urandom_range(0, 99);
                if (fill_mode)
                    fop = (pick < 50) ? hkts_pkg::OP_TOGGLE :
                          (pick < 80) ? hkts_pkg::OP_LOAD_KEY : hkts_pkg::OP_QUERY;
                else
                    fop = (pick < 75) ? hkts_pkg::OP_TOGGLE :
                          (pick < 95) ? hkts_pkg::OP_QUERY : hkts_pkg::OP_LOAD_KEY;
                send_key($urandom_range(0, POOL_KEYS - 1), fop);
            end
        end

        // wait for the last results, then let the core settle
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d key, word and clear transfers; %0d results checked,",
                 beats_sent, n_results);
        $display("%0d removals, %0d rejections, table peaked at %0d of %0d entries, %0d errors",
                 n_removed, n_rejected, peak_count, TABLE_DEPTH, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
